### sv/ocva_pkg.sv
// Shared types and codes of the output VC credit allocator.
`timescale 1ns / 1ps
package ocva_pkg;

   localparam int CMD_W      = 3;
   localparam int VNET_W     = 4;
   localparam int VC_W       = 6;
   localparam int OFFSET_W   = 4;
   localparam int COUNT_W    = 5;
   localparam int FREE_CNT_W = 5;
   localparam int SUM_W      = 9;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 5;

   localparam logic [CMD_W-1:0] CMD_ALLOC_WINDOW  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC_CLASS   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ALLOC_ANY     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEND_FLIT     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CREDIT_RETURN = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE_FIRST   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE_COUNT   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ADAPTIVE_FIRST = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ADAPTIVE_COUNT = 4'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [VNET_W-1:0]   vnet;
      logic [VC_W-1:0]     vc;
      logic [OFFSET_W-1:0] win_first;
      logic [COUNT_W-1:0]  window_count;
      logic                use_escape;
      logic                take_active;
      logic                free_signal;
   } req_item_type;

   typedef struct packed {
      logic                  granted;
      logic [VC_W-1:0]       granted_vc;
      logic                  error;
      logic [FREE_CNT_W-1:0] free_vc_count;
      logic                  vnet_has_credit;
      logic [SUM_W-1:0]      window_free_credits;
      logic [SUM_W-1:0]      class_free_credits;
   } rsp_item_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] escape_first;
      logic [COUNT_W-1:0]  escape_count;
      logic [OFFSET_W-1:0] adaptive_first;
      logic [COUNT_W-1:0]  adaptive_count;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      escape_first:   4'd0,
      escape_count:   5'd1,
      adaptive_first: 4'd1,
      adaptive_count: 5'd3
   };

   typedef struct packed {
      logic            vnet_ok;
      logic            granted;
      logic [VC_W-1:0] granted_vc;
      logic            error;
   } exec_status_type;

endpackage

### sv/ocva_if.sv
// Channel interfaces for the command, result and register write transfers.
`timescale 1ns / 1ps
interface ocva_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [3:0] vnet;
   logic [5:0] vc;
   logic [3:0] win_first;
   logic [4:0] window_count;
   logic       use_escape;
   logic       take_active;
   logic       free_signal;

   modport source (
      output valid, command, vnet, vc, win_first, window_count,
             use_escape, take_active, free_signal,
      input  ready
   );
   modport sink (
      input  valid, command, vnet, vc, win_first, window_count,
             use_escape, take_active, free_signal,
      output ready
   );
endinterface

interface ocva_rsp_if;
   logic       valid;
   logic       ready;
   logic       granted;
   logic [5:0] granted_vc;
   logic       error;
   logic [4:0] free_vc_count;
   logic       vnet_has_credit;
   logic [8:0] window_free_credits;
   logic [8:0] class_free_credits;

   modport source (
      output valid, granted, granted_vc, error, free_vc_count, vnet_has_credit,
             window_free_credits, class_free_credits,
      input  ready
   );
   modport sink (
      input  valid, granted, granted_vc, error, free_vc_count, vnet_has_credit,
             window_free_credits, class_free_credits,
      output ready
   );
endinterface

interface ocva_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] index;
   logic [4:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/ocva_exec.sv
// Command decode, VC selection and next credit/active state.
`timescale 1ns / 1ps
module ocva_exec #(
   parameter int NUM_VNETS    = 4,
   parameter int VCS_PER_VNET = 4,
   parameter int BUFFER_DEPTH = 4,
   parameter int CW           = $clog2(BUFFER_DEPTH + 1)
) (
   input  ocva_pkg::req_item_type                                item,
   input  ocva_pkg::cfg_type                                     cfg,
   input  logic [NUM_VNETS-1:0][VCS_PER_VNET-1:0][CW-1:0]        credits_q,
   input  logic [NUM_VNETS-1:0][VCS_PER_VNET-1:0]                active_q,
   output logic [NUM_VNETS-1:0][VCS_PER_VNET-1:0][CW-1:0]        credits_d,
   output logic [NUM_VNETS-1:0][VCS_PER_VNET-1:0]                active_d,
   output logic [VCS_PER_VNET-1:0][CW-1:0]                       row_credits,
   output logic [VCS_PER_VNET-1:0]                               row_active,
   output logic [VCS_PER_VNET-1:0]                               win_mask,
   output logic [VCS_PER_VNET-1:0]                               cls_mask,
   output ocva_pkg::exec_status_type                             status
);
   import ocva_pkg::*;

   localparam int OW = (VCS_PER_VNET > 1) ? $clog2(VCS_PER_VNET) : 1;

   always_comb begin
      logic [VCS_PER_VNET-1:0][CW-1:0] sel_credits;
      logic [VCS_PER_VNET-1:0]         sel_active;
      logic [VCS_PER_VNET-1:0]         cand;
      logic [VCS_PER_VNET-1:0]         pick_oh;
      logic [OW-1:0]                   pick_off;
      logic [OFFSET_W-1:0]             cls_first;
      logic [COUNT_W-1:0]              cls_count;
      logic                            hit;

      status.vnet_ok = 32'(item.vnet) < NUM_VNETS;
      sel_credits = '0;
      sel_active  = '0;
      for (int v = 0; v < NUM_VNETS; v++) begin
         if (32'(item.vnet) == v) begin
            sel_credits = credits_q[v];
            sel_active  = active_q[v];
         end
      end

      cls_first = item.use_escape ? cfg.escape_first : cfg.adaptive_first;
      cls_count = item.use_escape ? cfg.escape_count : cfg.adaptive_count;
      for (int o = 0; o < VCS_PER_VNET; o++) begin
         win_mask[o] = (o >= int'(item.win_first)) &&
                       (o < int'(item.win_first) + int'(item.window_count));
         cls_mask[o] = (o >= int'(cls_first)) && (o < int'(cls_first) + int'(cls_count));
      end

      case (item.command)
         CMD_ALLOC_WINDOW: cand = win_mask & ~sel_active;
         CMD_ALLOC_CLASS:  cand = cls_mask & ~sel_active;
         CMD_ALLOC_ANY: begin
            for (int o = 0; o < VCS_PER_VNET; o++) begin
               cand[o] = !sel_active[o] || (item.take_active && (sel_credits[o] != '0));
            end
         end
         default:          cand = '0;
      endcase
      if (!status.vnet_ok) begin
         cand = '0;
      end

      pick_oh  = cand & (~cand + VCS_PER_VNET'(1));
      pick_off = '0;
      for (int o = 0; o < VCS_PER_VNET; o++) begin
         if (pick_oh[o]) begin
            pick_off = pick_off | OW'(o);
         end
      end
      status.granted    = |cand;
      status.granted_vc = status.granted ?
                          VC_W'(32'(item.vnet) * VCS_PER_VNET + 32'(pick_off)) : '0;

      credits_d    = credits_q;
      active_d     = active_q;
      status.error = 1'b0;
      for (int v = 0; v < NUM_VNETS; v++) begin
         for (int o = 0; o < VCS_PER_VNET; o++) begin
            hit = 32'(item.vc) == 32'(v * VCS_PER_VNET + o);
            if ((32'(item.vnet) == v) && pick_oh[o]) begin
               active_d[v][o] = 1'b1;
            end
            if (hit) begin
               case (item.command)
                  CMD_SEND_FLIT: begin
                     if (credits_q[v][o] == '0) begin
                        status.error = 1'b1;
                     end else begin
                        credits_d[v][o] = credits_q[v][o] - CW'(1);
                     end
                  end
                  CMD_CREDIT_RETURN: begin
                     if (credits_q[v][o] >= CW'(BUFFER_DEPTH)) begin
                        credits_d[v][o] = CW'(BUFFER_DEPTH);
                        status.error    = 1'b1;
                     end else begin
                        credits_d[v][o] = credits_q[v][o] + CW'(1);
                     end
                     if (item.free_signal) begin
                        active_d[v][o] = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end

      row_credits = '0;
      row_active  = '0;
      for (int v = 0; v < NUM_VNETS; v++) begin
         if (32'(item.vnet) == v) begin
            row_credits = credits_d[v];
            row_active  = active_d[v];
         end
      end
   end

endmodule

### sv/ocva_stats.sv
// Idle count, credit presence and idle-VC credit sums of one vnet.
`timescale 1ns / 1ps
module ocva_stats #(
   parameter int VCS_PER_VNET = 4,
   parameter int BUFFER_DEPTH = 4,
   parameter int CW           = $clog2(BUFFER_DEPTH + 1)
) (
   input  logic                                 vnet_ok,
   input  logic [VCS_PER_VNET-1:0][CW-1:0]      row_credits,
   input  logic [VCS_PER_VNET-1:0]              row_active,
   input  logic [VCS_PER_VNET-1:0]              win_mask,
   input  logic [VCS_PER_VNET-1:0]              cls_mask,
   output logic [ocva_pkg::FREE_CNT_W-1:0]      free_vc_count,
   output logic                                 vnet_has_credit,
   output logic [ocva_pkg::SUM_W-1:0]           window_free_credits,
   output logic [ocva_pkg::SUM_W-1:0]           class_free_credits
);
   import ocva_pkg::*;

   localparam int SW = $clog2(VCS_PER_VNET * BUFFER_DEPTH + 1);
   localparam int NL = $clog2(VCS_PER_VNET);
   localparam int NP = 1 << NL;

   logic [SW-1:0] win_tree [NL+1][NP];
   logic [SW-1:0] cls_tree [NL+1][NP];

   // Idle-VC credit sums are formed in a balanced adder tree.
   always_comb begin
      logic any_credit;

      any_credit = 1'b0;
      for (int i = 0; i < NP; i++) begin
         win_tree[0][i] = '0;
         cls_tree[0][i] = '0;
         if (i < VCS_PER_VNET) begin
            if (win_mask[i] && !row_active[i]) begin
               win_tree[0][i] = SW'(row_credits[i]);
            end
            if (cls_mask[i] && !row_active[i]) begin
               cls_tree[0][i] = SW'(row_credits[i]);
            end
            any_credit = any_credit || (row_credits[i] != '0);
         end
      end
      for (int l = 1; l <= NL; l++) begin
         for (int i = 0; i < NP; i++) begin
            win_tree[l][i] = '0;
            cls_tree[l][i] = '0;
            if (i < (NP >> l)) begin
               win_tree[l][i] = win_tree[l-1][2*i] + win_tree[l-1][2*i+1];
               cls_tree[l][i] = cls_tree[l-1][2*i] + cls_tree[l-1][2*i+1];
            end
         end
      end

      free_vc_count       = vnet_ok ? FREE_CNT_W'($countones(~row_active)) : '0;
      vnet_has_credit     = vnet_ok && any_credit;
      window_free_credits = vnet_ok ? SUM_W'(win_tree[NL][0]) : '0;
      class_free_credits  = vnet_ok ? SUM_W'(cls_tree[NL][0]) : '0;
   end

endmodule

### sv/output_vc_credit_allocator.sv
// Top level of the output VC allocator with credit-based flow control.
//
// Commands arrive on req_chan and one result per command leaves on
// rsp_chan; both are valid/ready channels and a transfer happens when
// valid and ready are high at a rising clock edge. csr_chan writes the
// class window registers (escape first/count, adaptive first/count) and
// is always ready; registers must be written only while the block is idle,
// which the block itself does not enforce. A command is captured in an
// input register, the VC selection and credit update run in combinational
// logic, and the result is captured in an output register before it is offered.
// One command is taken every cycle while no result is stalled; the limit is
// the read-modify-write of the credit and active flip-flops per command.
// When the receiver stalls, the result is held and an empty input register
// still takes one more command, after which req_chan ready drops.
// Synchronous reset empties both registers, restores the register
// defaults, sets every VC idle and loads every credit counter with
// BUFFER_DEPTH; the block takes commands in the cycle after reset.
`timescale 1ns / 1ps
module output_vc_credit_allocator #(
   parameter int NUM_VNETS    = 4,
   parameter int VCS_PER_VNET = 4,
   parameter int BUFFER_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   ocva_req_if.sink          req_chan,
   ocva_rsp_if.source        rsp_chan,
   ocva_csr_if.sink          csr_chan
);
   import ocva_pkg::*;

   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   logic                                          req_valid_ff;
   req_item_type                                  req_item_ff;
   req_item_type                                  req_item_in;
   logic                                          rsp_valid_ff;
   rsp_item_type                                  rsp_item_ff;
   rsp_item_type                                  rsp_item_in;
   cfg_type                                       cfg_ff;
   logic [NUM_VNETS-1:0][VCS_PER_VNET-1:0][CW-1:0] credits_ff;
   logic [NUM_VNETS-1:0][VCS_PER_VNET-1:0][CW-1:0] credits_in;
   logic [NUM_VNETS-1:0][VCS_PER_VNET-1:0]         active_ff;
   logic [NUM_VNETS-1:0][VCS_PER_VNET-1:0]         active_in;
   logic [VCS_PER_VNET-1:0][CW-1:0]               row_credits;
   logic [VCS_PER_VNET-1:0]                       row_active;
   logic [VCS_PER_VNET-1:0]                       win_mask;
   logic [VCS_PER_VNET-1:0]                       cls_mask;
   exec_status_type                               status;
   logic                                          advance;
   logic                                          fire;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_valid_ff && advance;
   assign req_chan.ready = !req_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign req_item_in = '{
      command:      req_chan.command,
      vnet:         req_chan.vnet,
      vc:           req_chan.vc,
      win_first:    req_chan.win_first,
      window_count: req_chan.window_count,
      use_escape:   req_chan.use_escape,
      take_active:  req_chan.take_active,
      free_signal:  req_chan.free_signal
   };

   ocva_exec #(
      .NUM_VNETS    (NUM_VNETS),
      .VCS_PER_VNET (VCS_PER_VNET),
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .CW           (CW)
   ) u_exec (
      .item        (req_item_ff),
      .cfg         (cfg_ff),
      .credits_q   (credits_ff),
      .active_q    (active_ff),
      .credits_d   (credits_in),
      .active_d    (active_in),
      .row_credits (row_credits),
      .row_active  (row_active),
      .win_mask    (win_mask),
      .cls_mask    (cls_mask),
      .status      (status)
   );

   ocva_stats #(
      .VCS_PER_VNET (VCS_PER_VNET),
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .CW           (CW)
   ) u_stats (
      .vnet_ok             (status.vnet_ok),
      .row_credits         (row_credits),
      .row_active          (row_active),
      .win_mask            (win_mask),
      .cls_mask            (cls_mask),
      .free_vc_count       (rsp_item_in.free_vc_count),
      .vnet_has_credit     (rsp_item_in.vnet_has_credit),
      .window_free_credits (rsp_item_in.window_free_credits),
      .class_free_credits  (rsp_item_in.class_free_credits)
   );

   assign rsp_item_in.granted    = status.granted;
   assign rsp_item_in.granted_vc = status.granted_vc;
   assign rsp_item_in.error      = status.error;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= CFG_RESET;
         active_ff    <= '0;
         for (int v = 0; v < NUM_VNETS; v++) begin
            for (int o = 0; o < VCS_PER_VNET; o++) begin
               credits_ff[v][o] <= CW'(BUFFER_DEPTH);
            end
         end
      end else begin
         if (req_chan.ready) begin
            req_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (fire) begin
            credits_ff <= credits_in;
            active_ff  <= active_in;
         end
         if (csr_chan.valid) begin
            case (csr_chan.index)
               REG_ESCAPE_FIRST:   cfg_ff.escape_first   <= csr_chan.data[OFFSET_W-1:0];
               REG_ESCAPE_COUNT:   cfg_ff.escape_count   <= csr_chan.data[COUNT_W-1:0];
               REG_ADAPTIVE_FIRST: cfg_ff.adaptive_first <= csr_chan.data[OFFSET_W-1:0];
               REG_ADAPTIVE_COUNT: cfg_ff.adaptive_count <= csr_chan.data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_item_ff <= req_item_in;
      end
      if (fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.granted             = rsp_item_ff.granted;
   assign rsp_chan.granted_vc          = rsp_item_ff.granted_vc;
   assign rsp_chan.error               = rsp_item_ff.error;
   assign rsp_chan.free_vc_count       = rsp_item_ff.free_vc_count;
   assign rsp_chan.vnet_has_credit     = rsp_item_ff.vnet_has_credit;
   assign rsp_chan.window_free_credits = rsp_item_ff.window_free_credits;
   assign rsp_chan.class_free_credits  = rsp_item_ff.class_free_credits;

endmodule

### sv/ocva_checker.sv
// Port-level checks of the allocator and their attachment to the top level.
`timescale 1ns / 1ps
module ocva_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       granted,
   input logic [5:0] granted_vc,
   input logic       error
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(granted) && $stable(granted_vc) && $stable(error))
      else $error("result payload changed while stalled");

   // No result is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // With no result waiting, the block always takes a command.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("command refused while output is empty");

   // A grant never comes with an error, and a miss reports VC zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(granted && error) && (granted || granted_vc == 6'd0))
      else $error("inconsistent grant and error fields");

endmodule

bind output_vc_credit_allocator ocva_checker u_ocva_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .granted    (rsp_chan.granted),
   .granted_vc (rsp_chan.granted_vc),
   .error      (rsp_chan.error)
);

### bench/tb_output_vc_credit_allocator.sv
// Self-checking testbench for the output VC credit allocator.
`timescale 1ns / 1ps
module tb_output_vc_credit_allocator;
   import ocva_pkg::*;

   localparam int NUM_VNETS       = 4;
   localparam int VCS_PER_VNET    = 4;
   localparam int BUFFER_DEPTH    = 4;
   localparam int TOTAL_VCS       = NUM_VNETS * VCS_PER_VNET;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 280;
   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_CYCLES     = 80;
   localparam int MAX_REPORTS     = 100;

   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

   typedef struct {
      bit           has_typed;
      rsp_item_type report;
   } typed_report_type;

   typedef struct {
      req_item_type cmd;
      bit           has_typed;
      rsp_item_type report;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ocva_req_if req_bus ();
   ocva_rsp_if rsp_bus ();
   ocva_csr_if csr_bus ();

   output_vc_credit_allocator #(
      .NUM_VNETS    (NUM_VNETS),
      .VCS_PER_VNET (VCS_PER_VNET),
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #5 clock = ~clock;

   logic [4:0]       credit_level [TOTAL_VCS];
   logic             vc_busy [TOTAL_VCS];
   cfg_type          class_cfg;
   rsp_item_type     pending_reports [$];
   typed_report_type typed_reports [$];
   directed_row_type directed_rows [$];
   int               mismatch_count = 0;
   int               result_count = 0;
   int               stall_cycles = 0;
   bit               no_idle = 1'b0;
   bit               hold_request = 1'b0;
   int               hold_left = 0;

   function automatic int unsigned window_end(int unsigned first, int unsigned count);
      if (first >= VCS_PER_VNET) return first;
      return (first + count > VCS_PER_VNET) ? VCS_PER_VNET : first + count;
   endfunction

   function automatic int claim_idle_vc(int unsigned vnet, int unsigned first,
                                        int unsigned count);
      int unsigned stop;
      int          g;
      stop = window_end(first, count);
      if (vnet >= NUM_VNETS) return -1;
      for (int unsigned off = first; off < stop; off++) begin
         g = vnet * VCS_PER_VNET + off;
         if (!vc_busy[g]) begin
            vc_busy[g] = 1'b1;
            return g;
         end
      end
      return -1;
   endfunction

   function automatic int unsigned idle_credit_sum(int unsigned vnet, int unsigned first,
                                                   int unsigned count);
      int unsigned stop;
      int unsigned sum;
      int          g;
      stop = window_end(first, count);
      sum = 0;
      if (vnet >= NUM_VNETS) return 0;
      for (int unsigned off = first; off < stop; off++) begin
         g = vnet * VCS_PER_VNET + off;
         if (!vc_busy[g]) sum += credit_level[g];
      end
      return sum;
   endfunction

   function automatic rsp_item_type apply_vc_command(req_item_type c);
      rsp_item_type r;
      int           pick;
      int           g;
      int unsigned  cls_first;
      int unsigned  cls_count;
      int unsigned  idle;
      r = '0;
      pick = -1;
      idle = 0;
      cls_first = c.use_escape ? class_cfg.escape_first : class_cfg.adaptive_first;
      cls_count = c.use_escape ? class_cfg.escape_count : class_cfg.adaptive_count;
      case (c.command)
         CMD_ALLOC_WINDOW: pick = claim_idle_vc(c.vnet, c.win_first, c.window_count);
         CMD_ALLOC_CLASS: pick = claim_idle_vc(c.vnet, cls_first, cls_count);
         CMD_ALLOC_ANY: begin
            if (c.vnet < NUM_VNETS) begin
               for (int off = 0; off < VCS_PER_VNET && pick < 0; off++) begin
                  g = c.vnet * VCS_PER_VNET + off;
                  if (!vc_busy[g] || (c.take_active && credit_level[g] != 0)) begin
                     vc_busy[g] = 1'b1;
                     pick = g;
                  end
               end
            end
         end
         CMD_SEND_FLIT: begin
            if (c.vc < TOTAL_VCS) begin
               if (credit_level[c.vc] == 0) r.error = 1'b1;
               else credit_level[c.vc] = credit_level[c.vc] - 5'd1;
            end
         end
         CMD_CREDIT_RETURN: begin
            if (c.vc < TOTAL_VCS) begin
               if (credit_level[c.vc] >= BUFFER_DEPTH) begin
                  credit_level[c.vc] = 5'(BUFFER_DEPTH);
                  r.error = 1'b1;
               end else begin
                  credit_level[c.vc] = credit_level[c.vc] + 5'd1;
               end
               if (c.free_signal) vc_busy[c.vc] = 1'b0;
            end
         end
         default: ;
      endcase
      if (c.vnet < NUM_VNETS) begin
         for (int off = 0; off < VCS_PER_VNET; off++) begin
            g = c.vnet * VCS_PER_VNET + off;
            if (!vc_busy[g]) idle++;
            if (credit_level[g] != 0) r.vnet_has_credit = 1'b1;
         end
      end
      r.granted = (pick >= 0);
      r.granted_vc = (pick >= 0) ? pick[VC_W-1:0] : '0;
      r.free_vc_count = idle[FREE_CNT_W-1:0];
      r.window_free_credits = SUM_W'(idle_credit_sum(c.vnet, c.win_first, c.window_count));
      r.class_free_credits = SUM_W'(idle_credit_sum(c.vnet, cls_first, cls_count));
      return r;
   endfunction

   function automatic req_item_type make_cmd(logic [CMD_W-1:0] command, int vnet, int vc,
                                             int first, int count, bit esc, bit allow,
                                             bit free);
      req_item_type c;
      c.command = command;
      c.vnet = vnet[VNET_W-1:0];
      c.vc = vc[VC_W-1:0];
      c.win_first = first[OFFSET_W-1:0];
      c.window_count = count[COUNT_W-1:0];
      c.use_escape = esc;
      c.take_active = allow;
      c.free_signal = free;
      return c;
   endfunction

   function automatic rsp_item_type make_report(bit granted, int vc, bit error, int idle,
                                                bit credit_seen, int win_sum, int cls_sum);
      rsp_item_type r;
      r.granted = granted;
      r.granted_vc = vc[VC_W-1:0];
      r.error = error;
      r.free_vc_count = idle[FREE_CNT_W-1:0];
      r.vnet_has_credit = credit_seen;
      r.window_free_credits = win_sum[SUM_W-1:0];
      r.class_free_credits = cls_sum[SUM_W-1:0];
      return r;
   endfunction

   function automatic cfg_type make_cfg(int esc_first, int esc_count, int ada_first,
                                        int ada_count);
      cfg_type c;
      c.escape_first = esc_first[OFFSET_W-1:0];
      c.escape_count = esc_count[COUNT_W-1:0];
      c.adaptive_first = ada_first[OFFSET_W-1:0];
      c.adaptive_count = ada_count[COUNT_W-1:0];
      return c;
   endfunction

   function automatic req_item_type random_cmd();
      req_item_type c;
      int unsigned  sel;
      sel = $urandom_range(99);
      if (sel < 20) c.command = CMD_ALLOC_WINDOW;
      else if (sel < 35) c.command = CMD_ALLOC_CLASS;
      else if (sel < 50) c.command = CMD_ALLOC_ANY;
      else if (sel < 75) c.command = CMD_SEND_FLIT;
      else if (sel < 97) c.command = CMD_CREDIT_RETURN;
      else c.command = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      c.vnet = VNET_W'(($urandom_range(99) < 85) ? $urandom_range(NUM_VNETS - 1)
                                                 : $urandom_range(15));
      c.vc = VC_W'(($urandom_range(99) < 85) ? $urandom_range(TOTAL_VCS - 1)
                                             : $urandom_range(63));
      c.win_first = OFFSET_W'(($urandom_range(99) < 80) ? $urandom_range(VCS_PER_VNET - 1)
                                                        : $urandom_range(15));
      c.window_count = COUNT_W'($urandom_range(1, 16));
      c.use_escape = 1'($urandom_range(1));
      c.take_active = 1'($urandom_range(1));
      c.free_signal = ($urandom_range(99) < 60);
      return c;
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
   endtask

   task automatic compare_field(string name, int unsigned seen, int unsigned want);
      if (seen != want)
         report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                   result_count, name, seen, want));
   endtask

   task automatic check_report(rsp_item_type seen);
      rsp_item_type want;
      if (pending_reports.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
         want = pending_reports.pop_front();
         compare_field("granted", seen.granted, want.granted);
         compare_field("granted_vc", seen.granted_vc, want.granted_vc);
         compare_field("error", seen.error, want.error);
         compare_field("free_vc_count", seen.free_vc_count, want.free_vc_count);
         compare_field("vnet_has_credit", seen.vnet_has_credit, want.vnet_has_credit);
         compare_field("window_free_credits", seen.window_free_credits,
                       want.window_free_credits);
         compare_field("class_free_credits", seen.class_free_credits,
                       want.class_free_credits);
      end
      result_count++;
   endtask

   always @(posedge clock) begin : track_transfers
      req_item_type     cmd;
      rsp_item_type     seen;
      rsp_item_type     want;
      typed_report_type typed;
      if (reset) begin
         class_cfg = CFG_RESET;
         for (int g = 0; g < TOTAL_VCS; g++) begin
            credit_level[g] = 5'(BUFFER_DEPTH);
            vc_busy[g] = 1'b0;
         end
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_ESCAPE_FIRST: class_cfg.escape_first = csr_bus.data[OFFSET_W-1:0];
               REG_ESCAPE_COUNT: class_cfg.escape_count = csr_bus.data;
               REG_ADAPTIVE_FIRST: class_cfg.adaptive_first = csr_bus.data[OFFSET_W-1:0];
               REG_ADAPTIVE_COUNT: class_cfg.adaptive_count = csr_bus.data;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.granted, rsp_bus.granted_vc, rsp_bus.error, rsp_bus.free_vc_count,
                    rsp_bus.vnet_has_credit, rsp_bus.window_free_credits,
                    rsp_bus.class_free_credits};
            check_report(seen);
         end
         if (req_bus.valid && req_bus.ready) begin
            cmd = {req_bus.command, req_bus.vnet, req_bus.vc, req_bus.win_first,
                   req_bus.window_count, req_bus.use_escape, req_bus.take_active,
                   req_bus.free_signal};
            want = apply_vc_command(cmd);
            typed = typed_reports.pop_front();
            if (typed.has_typed) want = typed.report;
            pending_reports.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= no_idle || ($urandom_range(99) >= 8);
         end
      end
   end

   task automatic send_cmd(req_item_type c, bit has_typed, rsp_item_type report);
      int gap;
      if (!no_idle && $urandom_range(99) < 8) begin
         gap = $urandom_range(1, 4);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_reports.push_back('{has_typed, report});
      req_bus.command <= c.command;
      req_bus.vnet <= c.vnet;
      req_bus.vc <= c.vc;
      req_bus.win_first <= c.win_first;
      req_bus.window_count <= c.window_count;
      req_bus.use_escape <= c.use_escape;
      req_bus.take_active <= c.take_active;
      req_bus.free_signal <= c.free_signal;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (typed_reports.size() != 0 || pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_bus.index <= index;
      csr_bus.data <= data;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic load_config(cfg_type c);
      write_reg(REG_ESCAPE_FIRST, {1'b0, c.escape_first});
      write_reg(REG_ESCAPE_COUNT, c.escape_count);
      write_reg(REG_ADAPTIVE_FIRST, {1'b0, c.adaptive_first});
      write_reg(REG_ADAPTIVE_COUNT, c.adaptive_count);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin : run_stimulus
      cfg_type phase_cfg [PHASES];
      req_bus.valid <= 1'b0;
      req_bus.command <= CMD_ALLOC_WINDOW;
      req_bus.vnet <= '0;
      req_bus.vc <= '0;
      req_bus.win_first <= '0;
      req_bus.window_count <= '0;
      req_bus.use_escape <= 1'b0;
      req_bus.take_active <= 1'b0;
      req_bus.free_signal <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= REG_ESCAPE_FIRST;
      csr_bus.data <= '0;

      // Rows with a typed report can be read off the reset state and the rows before them.
      directed_rows.push_back('{make_cmd(CMD_ALLOC_ANY, 0, 0, 0, 16, 1, 0, 0), 1'b1,
                                make_report(1, 0, 0, 3, 1, 12, 0)});
      directed_rows.push_back('{make_cmd(CMD_ALLOC_WINDOW, 3, 0, 15, 16, 0, 0, 0), 1'b1,
                                make_report(0, 0, 0, 4, 1, 0, 12)});
      directed_rows.push_back('{make_cmd(CMD_ALLOC_WINDOW, 15, 63, 0, 16, 1, 1, 1), 1'b1,
                                make_report(0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{make_cmd(CMD_CREDIT_RETURN, 0, 1, 0, 1, 0, 0, 1), 1'b1,
                                make_report(0, 0, 1, 3, 1, 0, 12)});
      repeat (4)
         directed_rows.push_back('{make_cmd(CMD_SEND_FLIT, 0, 2, 2, 1, 1, 0, 0), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_SEND_FLIT, 0, 2, 2, 1, 1, 0, 0), 1'b1,
                                make_report(0, 0, 1, 3, 1, 0, 0)});
      directed_rows.push_back('{make_cmd(CMD_SEND_FLIT, 1, 63, 0, 16, 1, 0, 0), 1'b1,
                                make_report(0, 0, 0, 4, 1, 16, 4)});
      directed_rows.push_back('{make_cmd(CMD_CREDIT_RETURN, 2, 16, 3, 1, 0, 0, 1), 1'b1,
                                make_report(0, 0, 0, 4, 1, 4, 12)});
      directed_rows.push_back('{make_cmd(CMD_ALLOC_CLASS, 0, 0, 0, 4, 1, 0, 0), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_ALLOC_CLASS, 0, 0, 0, 4, 0, 0, 0), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_ALLOC_WINDOW, 0, 0, 3, 1, 0, 0, 0), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_ALLOC_ANY, 0, 0, 0, 4, 0, 0, 0), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_ALLOC_ANY, 0, 0, 0, 4, 0, 0, 0), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_ALLOC_ANY, 0, 0, 0, 4, 0, 1, 0), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_CREDIT_RETURN, 0, 2, 0, 4, 1, 0, 0), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_CREDIT_RETURN, 0, 2, 0, 4, 1, 0, 1), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_SEND_FLIT, 1, 5, 0, 16, 0, 0, 0), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_ALLOC_WINDOW, 1, 0, 0, 16, 0, 0, 0), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_UNUSED_LAST, 2, 9, 1, 2, 1, 1, 1), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_UNUSED_FIRST, 3, 12, 0, 4, 0, 0, 0), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_ALLOC_ANY, 3, 0, 0, 4, 0, 1, 0), 1'b0, '0});
      directed_rows.push_back('{make_cmd(CMD_ALLOC_WINDOW, 3, 0, 1, 2, 1, 0, 0), 1'b0, '0});

      phase_cfg[0] = make_cfg(15, 16, 15, 16);
      phase_cfg[1] = make_cfg(0, 16, 0, 16);
      phase_cfg[2] = make_cfg(3, 1, 2, 2);
      phase_cfg[3] = make_cfg($urandom_range(0, 5), $urandom_range(1, 16),
                              $urandom_range(0, 5), $urandom_range(1, 16));
      phase_cfg[4] = make_cfg(0, 1, 1, 3);
      phase_cfg[5] = make_cfg($urandom_range(0, 5), $urandom_range(1, 16),
                              $urandom_range(0, 5), $urandom_range(1, 16));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_cmd(directed_rows[i].cmd, directed_rows[i].has_typed, directed_rows[i].report);

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         load_config(phase_cfg[p]);
         no_idle = (p == 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 3 && n == 40) hold_request = 1'b1;
            if (p == 4 && n == 150) drain_results();
            send_cmd(random_cmd(), 1'b0, '0);
         end
         no_idle = 1'b0;
      end

      drain_results();
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
